>>> design/spime_pkg.sv
// Shared types and constants for the SPI master bit engine.
package spime_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_SHIFT = 2'd2,
    PH_WAIT  = 2'd3
  } phase_t;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BIT_CNT_W  = 3;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETUP_DELAY    = 2'd3;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              byte_valid;
    logic              last_byte;
    logic              miso_level;
  } in_t;

  typedef struct packed {
    logic              sck_level;
    logic              mosi_level;
    logic              cs_level;
    logic              take_byte;
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_valid;
    logic              rx_last;
  } out_t;

  typedef struct packed {
    logic               clock_polarity;
    logic               clock_phase;
    logic               lsb_first;
    logic [DELAY_W-1:0] setup_delay;
  } cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [DELAY_W-1:0]   delay_count;
    logic [BIT_CNT_W-1:0] bit_count;
    logic                 second_half;
    logic [BYTE_W-1:0]    tx_shift;
    logic [BYTE_W-1:0]    rx_shift;
    logic                 sck;
    logic                 mosi;
    logic                 frame_ends;
  } state_t;

endpackage

>>> design/spime_step.sv
// Next-state and result logic for one serial clock tick.
module spime_step (
  input  spime_pkg::cfg_t   cfg,
  input  spime_pkg::state_t cur,
  input  spime_pkg::in_t    tick,
  output spime_pkg::state_t nxt,
  output spime_pkg::out_t   res
);

  logic [spime_pkg::DELAY_W-1:0] delay_dec;
  logic                          do_shift;

  assign delay_dec = (cur.delay_count != '0) ? cur.delay_count - 1'b1 : cur.delay_count;
  assign do_shift  = (cur.second_half == cfg.clock_phase);

  always_comb begin
    nxt          = cur;
    res          = '0;
    res.cs_level = 1'b1;
    unique case (cur.phase)
      spime_pkg::PH_IDLE, spime_pkg::PH_WAIT: begin
        nxt.sck = cfg.clock_polarity;
        if (tick.byte_valid) begin
          res.take_byte   = 1'b1;
          nxt.tx_shift    = tick.tx_byte;
          nxt.rx_shift    = '0;
          nxt.frame_ends  = tick.last_byte;
          nxt.bit_count   = '0;
          nxt.second_half = 1'b0;
          if (cur.phase == spime_pkg::PH_IDLE) begin
            nxt.delay_count = cfg.setup_delay;
            nxt.phase = (cfg.setup_delay != '0) ? spime_pkg::PH_SETUP : spime_pkg::PH_SHIFT;
          end else begin
            nxt.phase = spime_pkg::PH_SHIFT;
          end
        end else if (cur.phase == spime_pkg::PH_IDLE) begin
          res.cs_level = 1'b0;
        end
      end
      spime_pkg::PH_SETUP: begin
        nxt.sck         = cfg.clock_polarity;
        nxt.delay_count = delay_dec;
        if (delay_dec == '0) begin
          nxt.phase = spime_pkg::PH_SHIFT;
        end
      end
      spime_pkg::PH_SHIFT: begin
        nxt.sck = ~cur.sck;
        if (do_shift) begin
          if (cfg.lsb_first) begin
            nxt.mosi     = cur.tx_shift[0];
            nxt.tx_shift = {1'b0, cur.tx_shift[spime_pkg::BYTE_W-1:1]};
            nxt.rx_shift = {tick.miso_level, cur.rx_shift[spime_pkg::BYTE_W-1:1]};
          end else begin
            nxt.mosi     = cur.tx_shift[spime_pkg::BYTE_W-1];
            nxt.tx_shift = {cur.tx_shift[spime_pkg::BYTE_W-2:0], 1'b0};
            nxt.rx_shift = {cur.rx_shift[spime_pkg::BYTE_W-2:0], tick.miso_level};
          end
        end
        if (!cur.second_half) begin
          nxt.second_half = 1'b1;
        end else begin
          nxt.second_half = 1'b0;
          if (cur.bit_count == spime_pkg::LAST_BIT) begin
            // Byte complete: report it and park the clock at its idle level.
            nxt.bit_count = '0;
            res.rx_valid  = 1'b1;
            res.rx_byte   = nxt.rx_shift;
            res.rx_last   = cur.frame_ends;
            nxt.sck       = cfg.clock_polarity;
            if (cur.frame_ends) begin
              res.cs_level = 1'b0;
              nxt.phase    = spime_pkg::PH_IDLE;
            end else begin
              nxt.phase = spime_pkg::PH_WAIT;
            end
          end else begin
            nxt.bit_count = cur.bit_count + 1'b1;
          end
        end
      end
    endcase
    res.sck_level  = nxt.sck;
    res.mosi_level = nxt.mosi;
  end

endmodule

>>> design/spi_master_bit_engine.sv
// Top level of the SPI master bit engine: configuration, state and result registers.
//
//   channel  direction  handshake                 payload
//   in_      input      in_valid / in_stall       spime_pkg::in_t  (one tick)
//   out_     output     out_valid / out_stall     spime_pkg::out_t (line levels)
//   cfg_     input      cfg_wr_en                 cfg_index, cfg_data
//
// Every accepted tick yields one registered result; a tick can be taken each cycle
// while in_stall is low. The engine state and the result register load together.
// A stalled result holds the input side only until it is taken, then both move again.
// Synchronous active-low reset clears configuration, engine state and out_valid.
module spi_master_bit_engine (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  spime_pkg::in_t                        in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output spime_pkg::out_t                       out_data,
  input  logic                                  cfg_wr_en,
  input  logic [spime_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spime_pkg::CFG_DATA_W-1:0]      cfg_data
);

  spime_pkg::cfg_t   cfg_r;
  spime_pkg::state_t st_r;
  spime_pkg::state_t st_nxt;
  spime_pkg::out_t   res_nxt;
  spime_pkg::out_t   out_data_r;
  logic              out_valid_r;
  logic              in_xfer;

  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  spime_step u_step (
    .cfg  (cfg_r),
    .cur  (st_r),
    .tick (in_data),
    .nxt  (st_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        spime_pkg::CFG_CLOCK_POLARITY: cfg_r.clock_polarity <= cfg_data[0];
        spime_pkg::CFG_CLOCK_PHASE:    cfg_r.clock_phase    <= cfg_data[0];
        spime_pkg::CFG_LSB_FIRST:      cfg_r.lsb_first      <= cfg_data[0];
        spime_pkg::CFG_SETUP_DELAY:    cfg_r.setup_delay    <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: spime_pkg::PH_IDLE, default: '0};
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

>>> design/spime_checker.sv
// Port-level checker for the SPI master bit engine, with its bind.
module spime_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input spime_pkg::out_t out_data
);

  // A stalled result stays in place until its transfer completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every accepted tick produces a result on the next cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted tick gave no result");

  // A byte is only taken while chip select is asserted.
  a_take_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.take_byte |-> out_data.cs_level)
    else $error("byte taken with chip select low");

  // Completing a byte and taking a new one never happen on the same tick.
  a_no_take_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_valid |-> !out_data.take_byte)
    else $error("byte taken on completion tick");

  // Received fields read as zero when no byte completes.
  a_rx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.rx_valid |-> out_data.rx_byte == '0 && !out_data.rx_last)
    else $error("rx fields set without rx_valid");

endmodule

bind spi_master_bit_engine spime_checker u_spime_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> dv/spi_master_bit_engine_tb.sv
// Self-checking testbench for the SPI master bit engine, one serial-clock tick per transfer.
module spi_master_bit_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 40;
  localparam int MAX_WAIT     = 17;

  localparam logic [spime_pkg::BYTE_W-1:0] PATTERNS [8] = '{
    8'h00, 8'hFF, 8'h80, 8'h01, 8'hA5, 8'h5A, 8'hC3, 8'h3C
  };

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  spime_pkg::in_t                   in_data;
  logic                             out_valid;
  logic                             out_stall;
  spime_pkg::out_t                  out_data;
  logic                             cfg_wr_en;
  logic [spime_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spime_pkg::CFG_DATA_W-1:0] cfg_data;

  // Mirror of the engine: mode settings and shift state.
  logic                            mode_pol;
  logic                            mode_pha;
  logic                            mode_lsb;
  logic [spime_pkg::DELAY_W-1:0]   mode_delay;
  spime_pkg::phase_t               eng_phase;
  logic [spime_pkg::DELAY_W-1:0]   eng_delay;
  logic [spime_pkg::BIT_CNT_W-1:0] eng_bits;
  logic                            eng_half;
  logic [spime_pkg::BYTE_W-1:0]    eng_tx;
  logic [spime_pkg::BYTE_W-1:0]    eng_rx;
  logic                            eng_sck;
  logic                            eng_mosi;
  logic                            eng_last;

  spime_pkg::out_t              expected_levels [$];
  logic [spime_pkg::BYTE_W-1:0] frame_bytes [$];

  int errors       = 0;
  int cycles       = 0;
  int ticks_sent   = 0;
  int hold_cycles  = 0;
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;

  spi_master_bit_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_wait(input bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void load_frame_byte(input spime_pkg::in_t t);
    eng_tx   = t.tx_byte;
    eng_rx   = '0;
    eng_last = t.last_byte;
    eng_bits = '0;
    eng_half = 1'b0;
  endfunction

  // Advances the mirrored engine by one tick and returns the line levels it should show.
  function automatic spime_pkg::out_t advance_engine(input spime_pkg::in_t t);
    spime_pkg::out_t o;
    o = '0;
    o.cs_level = 1'b1;
    case (eng_phase)
      spime_pkg::PH_IDLE: begin
        eng_sck = mode_pol;
        if (t.byte_valid) begin
          o.take_byte = 1'b1;
          load_frame_byte(t);
          eng_delay = mode_delay;
          eng_phase = (mode_delay != '0) ? spime_pkg::PH_SETUP : spime_pkg::PH_SHIFT;
        end else begin
          o.cs_level = 1'b0;
        end
      end
      spime_pkg::PH_SETUP: begin
        eng_sck = mode_pol;
        if (eng_delay != '0) eng_delay = eng_delay - 1'b1;
        if (eng_delay == '0) eng_phase = spime_pkg::PH_SHIFT;
      end
      spime_pkg::PH_SHIFT: begin
        eng_sck = ~eng_sck;
        // MOSI is driven and MISO sampled on the same half-tick.
        if (eng_half == mode_pha) begin
          if (mode_lsb) begin
            eng_mosi = eng_tx[0];
            eng_tx   = eng_tx >> 1;
            eng_rx   = {t.miso_level, eng_rx[spime_pkg::BYTE_W-1:1]};
          end else begin
            eng_mosi = eng_tx[spime_pkg::BYTE_W-1];
            eng_tx   = eng_tx << 1;
            eng_rx   = {eng_rx[spime_pkg::BYTE_W-2:0], t.miso_level};
          end
        end
        if (!eng_half) begin
          eng_half = 1'b1;
        end else begin
          eng_half = 1'b0;
          if (eng_bits == spime_pkg::LAST_BIT) begin
            eng_bits   = '0;
            o.rx_valid = 1'b1;
            o.rx_byte  = eng_rx;
            o.rx_last  = eng_last;
            eng_sck    = mode_pol;
            if (eng_last) begin
              o.cs_level = 1'b0;
              eng_phase  = spime_pkg::PH_IDLE;
            end else begin
              eng_phase = spime_pkg::PH_WAIT;
            end
          end else begin
            eng_bits = eng_bits + 1'b1;
          end
        end
      end
      default: begin
        eng_sck = mode_pol;
        if (t.byte_valid) begin
          o.take_byte = 1'b1;
          load_frame_byte(t);
          eng_phase = spime_pkg::PH_SHIFT;
        end
      end
    endcase
    o.sck_level  = eng_sck;
    o.mosi_level = eng_mosi;
    return o;
  endfunction

  task automatic send_tick(input spime_pkg::in_t t);
    int gap;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    expected_levels.push_back(advance_engine(t));
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  // Writes all four registers; the one-bit registers get random upper bits.
  task automatic apply_settings(input logic pol, input logic pha, input logic lsb,
                                input logic [spime_pkg::DELAY_W-1:0] delay);
    logic [spime_pkg::CFG_IDX_W-1:0]  reg_id [4];
    logic [spime_pkg::CFG_DATA_W-1:0] reg_val [4];
    logic [31:0]                      junk;
    junk    = $urandom;
    reg_id  = '{spime_pkg::CFG_CLOCK_POLARITY, spime_pkg::CFG_CLOCK_PHASE,
                spime_pkg::CFG_LSB_FIRST, spime_pkg::CFG_SETUP_DELAY};
    reg_val = '{{junk[14:0], pol}, {junk[29:15], pha}, {junk[31:30], junk[12:0], lsb}, delay};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= reg_id[i];
      cfg_data  <= reg_val[i];
      @(posedge clk);
    end
    cfg_wr_en  <= 1'b0;
    mode_pol   = pol;
    mode_pha   = pha;
    mode_lsb   = lsb;
    mode_delay = delay;
  endtask

  task automatic send_noise(input int count);
    spime_pkg::in_t t;
    repeat (count) begin
      t.tx_byte    = 8'($urandom);
      t.byte_valid = 1'($urandom);
      t.last_byte  = 1'($urandom);
      t.miso_level = 1'($urandom);
      send_tick(t);
    end
  endtask

  // Sends the bytes in frame_bytes as one frame and keeps ticking until chip select drops.
  // While the engine is busy, some ticks offer a byte that must be ignored.
  task automatic send_frame(input int noise_pct, input int wait_pct, input int retune_at);
    spime_pkg::in_t t;
    int  taken;
    int  ticks;
    taken = 0;
    ticks = 0;
    while (taken < frame_bytes.size() || eng_phase != spime_pkg::PH_IDLE) begin
      t.tx_byte    = 8'($urandom);
      t.byte_valid = 1'b0;
      t.last_byte  = 1'($urandom);
      t.miso_level = 1'($urandom);
      if (taken < frame_bytes.size() && (eng_phase == spime_pkg::PH_IDLE ||
          (eng_phase == spime_pkg::PH_WAIT && $urandom_range(0, 99) >= wait_pct))) begin
        t.byte_valid = 1'b1;
        t.tx_byte    = frame_bytes[taken];
        t.last_byte  = (taken == frame_bytes.size() - 1);
        taken++;
      end else if (eng_phase != spime_pkg::PH_IDLE && eng_phase != spime_pkg::PH_WAIT &&
                   $urandom_range(0, 99) < noise_pct) begin
        t.byte_valid = 1'b1;
      end
      send_tick(t);
      ticks++;
      if (ticks == retune_at) begin
        drain_results();
        apply_settings(1'($urandom), 1'($urandom), 1'($urandom),
                       16'($urandom_range(0, 5)));
      end
    end
  endtask

  task automatic test_idle_line();
    spime_pkg::in_t t;
    apply_settings(1'b0, 1'b0, 1'b0, '0);
    repeat (5) begin
      t.tx_byte    = 8'($urandom);
      t.byte_valid = 1'b0;
      t.last_byte  = 1'($urandom);
      t.miso_level = 1'($urandom);
      send_tick(t);
    end
  endtask

  task automatic test_spi_modes();
    for (int m = 0; m < 4; m++) begin
      for (int l = 0; l < 2; l++) begin
        drain_results();
        apply_settings(m[1], m[0], l[0], '0);
        frame_bytes = '{PATTERNS[2 * m + l]};
        send_frame(0, 0, -1);
      end
    end
  endtask

  task automatic test_setup_delay();
    drain_results();
    apply_settings(1'b1, 1'b0, 1'b0, 16'd1);
    frame_bytes = '{8'h96};
    send_frame(20, 0, -1);
    // A longer setup wait runs with both sides at full rate.
    drain_results();
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    apply_settings(1'b0, 1'b1, 1'b1, 16'd40);
    frame_bytes = '{8'h69};
    send_frame(20, 0, -1);
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    drain_results();
    apply_settings(1'b1, 1'b1, 1'b0, 16'd3);
    frame_bytes = '{8'hF0, 8'h0F};
    send_frame(0, 0, -1);
  endtask

  task automatic test_multi_byte_frame();
    frame_bytes = '{};
    repeat (4) frame_bytes.push_back(8'($urandom));
    send_frame(50, 60, -1);
  endtask

  task automatic test_retune_mid_frame();
    frame_bytes = '{};
    repeat (3) frame_bytes.push_back(8'($urandom));
    send_frame(10, 30, 9);
  endtask

  task automatic test_backpressure();
    drain_results();
    sender_calm = 1'b1;
    hold_cycles = 250;
    frame_bytes = '{};
    repeat (3) frame_bytes.push_back(8'($urandom));
    send_frame(0, 0, -1);
    drain_results();
    sender_calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    start = ticks_sent;
    while (ticks_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_results();
        apply_settings(1'($urandom), 1'($urandom), 1'($urandom),
                       ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 40))
                                                   : 16'($urandom_range(0, 3)));
      end
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_noise(8);
      end else begin
        frame_bytes = '{};
        repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
        send_frame(10, 30, -1);
      end
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  // Result side: stalls a random number of cycles before each transfer.
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      n = draw_wait(receiver_calm);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_levels
    spime_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("cycle %0d: result with no tick pending, got %h",
                                   cycles, out_data);
      end else begin
        want = expected_levels.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("cycle %0d: mismatch sck/mosi/cs/take/rx/rxv/rxl", cycles);
            $display("  expected %b %b %b %b %h %b %b", want.sck_level, want.mosi_level,
                     want.cs_level, want.take_byte, want.rx_byte, want.rx_valid,
                     want.rx_last);
            $display("  actual   %b %b %b %b %h %b %b", out_data.sck_level,
                     out_data.mosi_level, out_data.cs_level, out_data.take_byte,
                     out_data.rx_byte, out_data.rx_valid, out_data.rx_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    mode_pol   = 1'b0;
    mode_pha   = 1'b0;
    mode_lsb   = 1'b0;
    mode_delay = '0;
    eng_phase  = spime_pkg::PH_IDLE;
    eng_delay  = '0;
    eng_bits   = '0;
    eng_half   = 1'b0;
    eng_tx     = '0;
    eng_rx     = '0;
    eng_sck    = 1'b0;
    eng_mosi   = 1'b0;
    eng_last   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_line();
    test_spi_modes();
    test_setup_delay();
    test_multi_byte_frame();
    test_retune_mid_frame();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
